[rtl/fba_pkg.sv]
// Package for the file block allocator: sizes, status and operation codes.
// No dependencies.
package fba_pkg;
  localparam int NUM_BLOCKS    = 4096;
  localparam int NUM_FILES     = 64;
  localparam int PTRS_PER_FILE = 8;
  localparam int BLOCK_BYTES   = 512;
  localparam int WORD_W        = 32;
  localparam int NUM_WORDS     = NUM_BLOCKS / WORD_W;
  localparam int BLK_W         = $clog2(NUM_BLOCKS);
  localparam int WADDR_W       = $clog2(NUM_WORDS);
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int FILE_W        = 6;
  localparam int PTR_W         = $clog2(PTRS_PER_FILE);
  localparam int CNT_W         = 4;
  localparam int SIZE_W        = 13;
  localparam int LIST_AW       = FILE_W + PTR_W;
  localparam int META_W        = SIZE_W + CNT_W;

  localparam logic [1:0] OP_FORMAT = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_BAD_FILE  = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_NO_SPACE  = 3'd4;
endpackage

[rtl/fba_ram.sv]
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/file_block_allocator_core.sv]
// File block allocator: bitmap memory, per-file metadata and block list memories.
// Depends on fba_pkg and fba_ram.
//
// Usage: a request transaction (operation, file_index, byte_count) enters on the
// in channel (in_valid / in_stall). Results leave on the out channel
// (out_valid / out_stall), one per mapped or allocated block, last marking the
// final one; all other requests give a single result.
// One request is worked on at a time. Format sweeps the 128-word bitmap, one
// word a cycle. Create claims the lowest free slot and writes empty metadata.
// A write walks the old block list, a read-modify-write of a bitmap word
// per old block, then for each new block scans the bitmap word by word from
// the lowest word, then emits one result per block. A read emits one result
// per block of the file, up to the requested byte count.
// After reset the block is not ready until a format; the bitmap memory holds
// junk until the format sweep, and every request but format answers not ready.
// When the receiver stalls, the result holds in the output register and the
// engine waits; no result is lost.
module file_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [5:0]                    file_index,
  input  logic [15:0]                   byte_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [5:0]                    file_index_out,
  output logic [11:0]                   block_number,
  output logic [9:0]                    chunk_bytes,
  output logic [12:0]                   byte_total,
  output logic                          last
);
  import fba_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FMT    = 4'd1;
  localparam logic [3:0] S_META   = 4'd2;
  localparam logic [3:0] S_DEC    = 4'd3;
  localparam logic [3:0] S_FRL    = 4'd4;
  localparam logic [3:0] S_FRW    = 4'd5;
  localparam logic [3:0] S_FRM    = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_TAKE   = 4'd8;
  localparam logic [3:0] S_RBL    = 4'd9;
  localparam logic [3:0] S_RBW    = 4'd10;
  localparam logic [3:0] S_RBM    = 4'd11;
  localparam logic [3:0] S_EMITL  = 4'd12;
  localparam logic [3:0] S_EMITW  = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;
  localparam logic [3:0] S_WAIT   = 4'd15;

  logic [3:0]  state;
  logic        ready;
  logic [NUM_FILES-1:0] used;
  logic [1:0]  op;
  logic [FILE_W-1:0] fi;
  logic [15:0] bytes;
  logic [SIZE_W-1:0] tot;
  logic [CNT_W-1:0] n;      // block count in play
  logic [CNT_W-1:0] k;      // pointer index
  logic [WADDR_W:0] widx;   // sweep / scan word counter
  logic        is_write;
  logic [SIZE_W-1:0] remain;

  // bitmap memory
  logic               bm_we;
  logic [WADDR_W-1:0] bm_waddr, bm_raddr;
  logic [WORD_W-1:0]  bm_wdata, bm_rdata;
  // metadata memory {size, count}
  logic               md_we;
  logic [META_W-1:0]  md_wdata, md_rdata;
  // block list memory
  logic               bl_we;
  logic [LIST_AW-1:0] bl_waddr, bl_raddr;
  logic [BLK_W-1:0]   bl_wdata, bl_rdata;
  logic [BLK_W-1:0]   blk;
  logic [BLK_W-1:0]   held_blk;

  fba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata));
  fba_ram #(.WIDTH(META_W), .DEPTH(NUM_FILES)) u_meta (
    .clk(clk), .we(md_we), .waddr(fi), .wdata(md_wdata),
    .raddr(fi), .rdata(md_rdata));
  fba_ram #(.WIDTH(BLK_W), .DEPTH(NUM_FILES * PTRS_PER_FILE)) u_list (
    .clk(clk), .we(bl_we), .waddr(bl_waddr), .wdata(bl_wdata),
    .raddr(bl_raddr), .rdata(bl_rdata));

  // lowest zero bit of the read word
  logic [BIT_W-1:0] zpos;
  logic             zfound;
  always_comb begin
    zpos = '0;
    zfound = 1'b0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!bm_rdata[i]) begin
        zpos = BIT_W'(i);
        zfound = 1'b1;
      end
    end
  end

  // lowest unused slot
  logic [FILE_W-1:0] free_slot;
  logic              slot_found;
  always_comb begin
    free_slot = '0;
    slot_found = 1'b0;
    for (int i = NUM_FILES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = FILE_W'(i);
        slot_found = 1'b1;
      end
    end
  end

  logic [16:0] need_full;
  assign need_full = ({1'b0, bytes} + 17'(BLOCK_BYTES - 1)) >> $clog2(BLOCK_BYTES);
  logic [SIZE_W-1:0] md_size;
  logic [CNT_W-1:0]  md_cnt;
  assign md_size = md_rdata[META_W-1:CNT_W];
  assign md_cnt  = md_rdata[CNT_W-1:0];
  logic [SIZE_W-1:0] chunk;
  assign chunk = (remain > SIZE_W'(BLOCK_BYTES)) ? SIZE_W'(BLOCK_BYTES) : remain;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign bl_raddr = {fi, k[PTR_W-1:0]};
  assign blk = held_blk;

  // result register
  task automatic post(input logic [2:0] st, input logic [FILE_W-1:0] f,
                      input logic [BLK_W-1:0] b, input logic [9:0] c,
                      input logic [SIZE_W-1:0] t, input logic l);
    out_valid      <= 1'b1;
    status         <= st;
    file_index_out <= f;
    block_number   <= b;
    chunk_bytes    <= c;
    byte_total     <= t;
    last           <= l;
  endtask

  // memory write controls and bitmap read address
  always_comb begin
    bm_we = 1'b0;
    bm_waddr = widx[WADDR_W-1:0];
    bm_wdata = '0;
    bm_raddr = widx[WADDR_W-1:0];
    md_we = 1'b0;
    md_wdata = '0;
    bl_we = 1'b0;
    bl_waddr = {fi, k[PTR_W-1:0]};
    bl_wdata = '0;
    unique case (state)
      S_FMT: bm_we = 1'b1;
      S_FRL, S_RBL, S_EMITL: ;
      S_FRW, S_RBW: bm_raddr = bl_rdata[BLK_W-1:BIT_W];
      S_FRM, S_RBM: begin
        bm_we = 1'b1;
        bm_waddr = blk[BLK_W-1:BIT_W];
        bm_wdata = bm_rdata & ~(WORD_W'(1) << blk[BIT_W-1:0]);
      end
      S_TAKE: begin
        bm_we = zfound;
        bm_wdata = bm_rdata | (WORD_W'(1) << zpos);
        bl_we = zfound;
        bl_wdata = {widx[WADDR_W-1:0], zpos};
      end
      S_DEC: if (op == OP_WRITE || op == OP_CREATE) begin
        md_we = 1'b1;
        md_wdata = '0;
      end
      S_EMIT: if (is_write && k == '0) begin
        md_we = 1'b1;
        md_wdata = {tot, n};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken; the emit state refills it itself
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          op <= operation;
          fi <= file_index;
          bytes <= byte_count;
          k <= '0;
          widx <= '0;
          if (operation == OP_FORMAT) begin
            used <= '0;
            state <= S_FMT;
          end else if (!ready) begin
            post(ST_NOT_READY, file_index, '0, '0, '0, 1'b1);
          end else if (operation == OP_CREATE) begin
            if (slot_found) begin
              used[free_slot] <= 1'b1;
              fi <= free_slot;
              state <= S_DEC; // writes empty metadata
              is_write <= 1'b0;
            end else begin
              post(ST_NO_SPACE, file_index, '0, '0, '0, 1'b1);
            end
          end else if (!used[file_index]) begin
            post(ST_BAD_FILE, file_index, '0, '0, '0, 1'b1);
          end else begin
            state <= S_META;
          end
        end
        S_FMT: begin
          widx <= widx + 1'b1;
          if (widx == (WADDR_W+1)'(NUM_WORDS - 1)) begin
            ready <= 1'b1;
            post(ST_OK, fi, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end
        end
        S_META: state <= S_DEC;
        S_DEC: begin
          // metadata read data is valid here for read and write
          n <= md_cnt;
          tot <= md_size;
          k <= '0;
          if (op == OP_CREATE) begin
            post(ST_OK, fi, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end else if (op == OP_READ) begin
            is_write <= 1'b0;
            tot <= (bytes > 16'(md_size)) ? md_size : bytes[SIZE_W-1:0];
            remain <= (bytes > 16'(md_size)) ? md_size : bytes[SIZE_W-1:0];
            if (md_cnt == '0 || bytes == '0 || md_size == '0) begin
              post(ST_OK, fi, '0, '0, '0, 1'b1);
              state <= S_IDLE;
            end else begin
              state <= S_EMITL;
            end
          end else begin
            is_write <= 1'b1;
            if (md_cnt == '0) state <= S_SCAN;
            else state <= S_FRL;
            widx <= '0;
          end
        end
        // free old blocks
        S_FRL: state <= S_FRW;
        S_FRW: begin
          held_blk <= bl_rdata;
          state <= S_FRM;
        end
        S_FRM: begin
          if (k + 1'b1 == n) begin
            k <= '0;
            widx <= '0;
            state <= S_SCAN;
          end else begin
            k <= k + 1'b1;
            state <= S_FRL;
          end
        end
        S_SCAN: begin
          // decide on size once old blocks are freed
          if (need_full > 17'(PTRS_PER_FILE)) begin
            post(ST_TOO_LARGE, fi, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end else if (need_full == '0) begin
            post(ST_OK, fi, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end else if (k == need_full[CNT_W-1:0]) begin
            n <= k;
            tot <= bytes[SIZE_W-1:0];
            remain <= bytes[SIZE_W-1:0];
            k <= '0;
            state <= S_EMITL;
          end else if (widx == (WADDR_W+1)'(NUM_WORDS)) begin
            n <= k;
            k <= '0;
            state <= S_RBL;
          end else begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          if (zfound) begin
            k <= k + 1'b1;
            widx <= '0;
          end else begin
            widx <= widx + 1'b1;
          end
          state <= S_SCAN;
        end
        // roll back blocks taken by this write
        S_RBL: begin
          if (k == n) begin
            post(ST_NO_SPACE, fi, '0, '0, '0, 1'b1);
            state <= S_IDLE;
          end else begin
            state <= S_RBW;
          end
        end
        S_RBW: begin
          held_blk <= bl_rdata;
          state <= S_RBM;
        end
        S_RBM: begin
          k <= k + 1'b1;
          state <= S_RBL;
        end
        // emit one result per block
        S_EMITL: state <= S_EMITW;
        S_EMITW: state <= S_EMIT;
        S_EMIT: if (!out_valid || !out_stall) begin
          post(ST_OK, fi, bl_rdata, chunk[9:0], tot,
               (k + 1'b1 == n) || (remain <= SIZE_W'(BLOCK_BYTES)));
          remain <= remain - chunk;
          if ((k + 1'b1 == n) || (remain <= SIZE_W'(BLOCK_BYTES))) begin
            state <= S_WAIT;
          end else begin
            k <= k + 1'b1;
            state <= S_EMITL;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/tb_file_block_allocator_core.sv]
// Testbench for file_block_allocator_core: directed and random requests with
// a built-in allocation predictor and in-order result checking.
// Depends on fba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_file_block_allocator_core;
  import fba_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  fidx;
    logic [15:0] nbytes;
  } request_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [5:0]  fidx;
    logic [11:0] blk;
    logic [9:0]  chunk;
    logic [12:0] total;
    logic        fin;
  } result_t;

  localparam int STALL_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [5:0]  file_index = '0;
  logic [15:0] byte_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  file_index_out;
  logic [11:0] block_number;
  logic [9:0]  chunk_bytes;
  logic [12:0] byte_total;
  logic        last;

  // Predictor copy of the allocator state
  bit          fs_ready;
  bit          blk_taken [NUM_BLOCKS];
  bit          slot_used [NUM_FILES];
  int unsigned slot_size [NUM_FILES];
  int unsigned slot_nblk [NUM_FILES];
  int unsigned slot_blks [NUM_FILES][PTRS_PER_FILE];

  request_t    pending_reqs[$];
  result_t     expected_results[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          reqs_sent = 0;
  int          quiet_cycles = 0;
  int          wr_ok = 0;
  int          nospace_seen = 0;

  file_block_allocator_core uut (.*);

  always #10 clk = ~clk;

  function automatic result_t mk(logic [2:0] st, int fi, int blk, int ch, int tot, bit f);
    result_t r;
    r.st = st; r.fidx = fi[5:0]; r.blk = blk[11:0]; r.chunk = ch[9:0];
    r.total = tot[12:0]; r.fin = f;
    return r;
  endfunction

  function automatic void wipe_store();
    foreach (blk_taken[i]) blk_taken[i] = 1'b0;
    for (int f = 0; f < NUM_FILES; f++) begin
      slot_used[f] = 1'b0; slot_size[f] = 0; slot_nblk[f] = 0;
      for (int p = 0; p < PTRS_PER_FILE; p++) slot_blks[f][p] = 0;
    end
  endfunction

  // Compute the results of one request and advance the predictor state
  function automatic void predict_allocation(request_t rq);
    int fi;
    int n;
    int need;
    int amount;
    int remain;
    int ch;
    int b;
    bit got;
    fi = int'(rq.fidx);
    if (rq.op == OP_FORMAT) begin
      wipe_store();
      fs_ready = 1'b1;
      expected_results.push_back(mk(ST_OK, fi, 0, 0, 0, 1'b1));
      return;
    end
    if (!fs_ready) begin
      expected_results.push_back(mk(ST_NOT_READY, fi, 0, 0, 0, 1'b1));
      return;
    end
    if (rq.op == OP_CREATE) begin
      for (int s = 0; s < NUM_FILES; s++)
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1; slot_size[s] = 0; slot_nblk[s] = 0;
          expected_results.push_back(mk(ST_OK, s, 0, 0, 0, 1'b1));
          return;
        end
      nospace_seen++;
      expected_results.push_back(mk(ST_NO_SPACE, fi, 0, 0, 0, 1'b1));
      return;
    end
    if (!slot_used[fi]) begin
      expected_results.push_back(mk(ST_BAD_FILE, fi, 0, 0, 0, 1'b1));
      return;
    end
    if (rq.op == OP_WRITE) begin
      // release the old blocks first
      for (int p = 0; p < int'(slot_nblk[fi]); p++) blk_taken[slot_blks[fi][p]] = 1'b0;
      slot_nblk[fi] = 0; slot_size[fi] = 0;
      need = (int'(rq.nbytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (need > PTRS_PER_FILE) begin
        expected_results.push_back(mk(ST_TOO_LARGE, fi, 0, 0, 0, 1'b1));
        return;
      end
      if (need == 0) begin
        expected_results.push_back(mk(ST_OK, fi, 0, 0, 0, 1'b1));
        return;
      end
      for (int k = 0; k < need; k++) begin
        got = 1'b0;
        for (b = 0; b < NUM_BLOCKS; b++) if (!blk_taken[b]) begin got = 1'b1; break; end
        if (!got) begin
          // roll back what this write took
          for (int j = 0; j < k; j++) blk_taken[slot_blks[fi][j]] = 1'b0;
          nospace_seen++;
          expected_results.push_back(mk(ST_NO_SPACE, fi, 0, 0, 0, 1'b1));
          return;
        end
        blk_taken[b] = 1'b1;
        slot_blks[fi][k] = unsigned'(b);
      end
      slot_nblk[fi] = unsigned'(need); slot_size[fi] = unsigned'(int'(rq.nbytes));
      wr_ok++;
      remain = int'(rq.nbytes);
      for (int k = 0; k < need; k++) begin
        ch = remain > BLOCK_BYTES ? BLOCK_BYTES : remain;
        remain -= ch;
        expected_results.push_back(mk(ST_OK, fi, int'(slot_blks[fi][k]), ch,
                                      int'(rq.nbytes), k + 1 == need));
      end
      return;
    end
    // read map: clamp to the file size
    amount = int'(rq.nbytes) > int'(slot_size[fi]) ? int'(slot_size[fi]) : int'(rq.nbytes);
    remain = amount;
    n = 0;
    for (int k = 0; k < int'(slot_nblk[fi]) && remain > 0; k++) begin
      ch = remain > BLOCK_BYTES ? BLOCK_BYTES : remain;
      remain -= ch;
      expected_results.push_back(mk(ST_OK, fi, int'(slot_blks[fi][k]), ch, amount, 1'b0));
      n++;
    end
    if (n == 0) expected_results.push_back(mk(ST_OK, fi, 0, 0, 0, 1'b1));
    else expected_results[$].fin = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Driver: present queued requests, honor stall, idle at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_allocation({operation, file_index, byte_count});
        reqs_sent++;
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_reqs.pop_front();
        in_valid <= 1'b1;
        operation <= rq.op; file_index <= rq.fidx; byte_count <= rq.nbytes;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest expectation; stall at random
  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", status, 0);
        end else begin
          w = expected_results.pop_front();
          if (status !== w.st) report_mismatch("status", status, w.st);
          if (file_index_out !== w.fidx) report_mismatch("file_index_out", file_index_out, w.fidx);
          if (block_number !== w.blk) report_mismatch("block_number", block_number, w.blk);
          if (chunk_bytes !== w.chunk) report_mismatch("chunk_bytes", chunk_bytes, w.chunk);
          if (byte_total !== w.total) report_mismatch("byte_total", byte_total, w.total);
          if (last !== w.fin) report_mismatch("last", last, w.fin);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic request_t req(logic [1:0] op, int fi, int nb);
    request_t r;
    r.op = op; r.fidx = fi[5:0]; r.nbytes = nb[15:0];
    return r;
  endfunction

  // Mostly writes/reads to the low slots 0..15, with some noise
  function automatic request_t random_req();
    int pick;
    pick = $urandom_range(99);
    if (pick < 2) return req(OP_FORMAT, $urandom_range(63), $urandom);
    if (pick < 14) return req(OP_CREATE, $urandom_range(63), $urandom);
    if (pick < 52) begin
      if ($urandom_range(9) == 0) return req(OP_WRITE, $urandom_range(63), $urandom);
      return req(OP_WRITE, $urandom_range(15), $urandom_range(4096));
    end
    if ($urandom_range(9) == 0) return req(OP_READ, $urandom_range(63), $urandom);
    return req(OP_READ, $urandom_range(15), $urandom_range(4200));
  endfunction

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: not-ready, format, create, extremes, bad slot, too large
    pending_reqs.push_back(req(OP_CREATE, 63, 0));
    pending_reqs.push_back(req(OP_WRITE, 0, 512));
    pending_reqs.push_back(req(OP_READ, 5, 65535));
    pending_reqs.push_back(req(OP_FORMAT, 42, 16'hFFFF));
    pending_reqs.push_back(req(OP_WRITE, 0, 100));
    pending_reqs.push_back(req(OP_CREATE, 0, 0));
    pending_reqs.push_back(req(OP_CREATE, 21, 16'hAAAA));
    pending_reqs.push_back(req(OP_WRITE, 0, 4096));
    pending_reqs.push_back(req(OP_READ, 0, 65535));
    pending_reqs.push_back(req(OP_READ, 0, 700));
    pending_reqs.push_back(req(OP_READ, 0, 0));
    pending_reqs.push_back(req(OP_WRITE, 1, 1));
    pending_reqs.push_back(req(OP_WRITE, 0, 4097));
    pending_reqs.push_back(req(OP_READ, 0, 100));
    pending_reqs.push_back(req(OP_WRITE, 1, 0));
    pending_reqs.push_back(req(OP_READ, 1, 10));
    pending_reqs.push_back(req(OP_WRITE, 1, 65535));
    pending_reqs.push_back(req(OP_WRITE, 63, 5));
    pending_reqs.push_back(req(OP_READ, 63, 5));
    pending_reqs.push_back(req(OP_WRITE, 0, 513));
    pending_reqs.push_back(req(OP_READ, 0, 1000));
    // fill every slot so create runs out of slots
    for (int i = 0; i < 64; i++) pending_reqs.push_back(req(OP_CREATE, 9, 0));
    pending_reqs.push_back(req(OP_WRITE, 63, 3000));
    pending_reqs.push_back(req(OP_READ, 63, 3000));
    pending_reqs.push_back(req(OP_FORMAT, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 17 : phase == 1 ? 65 : 0;
      recv_stall_pct = phase == 0 ? 65 : phase == 1 ? 17 : 0;
      for (int i = 0; i < 40; i++) pending_reqs.push_back(random_req());
      wait_drain();
    end
    repeat (300) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d successful writes, %0d out-of-space",
             reqs_sent, results_seen, wr_ok, nospace_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/file_block_allocator_core.sv
tb/tb_file_block_allocator_core.sv
